[design/lsc_pkg.sv]
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int COORD_W = 16;
  // magnitude product of two coordinate differences
  localparam int PROD_W  = 2 * COORD_W;
  // quotient magnitude saturates at 2^40
  localparam int QMAG_W  = 41;
  localparam int QCMP_W  = (PROD_W > QMAG_W) ? PROD_W : QMAG_W;
  localparam int QS_W    = QMAG_W + 1;
  localparam int SUM_W   = QS_W + 1;
  // two quotient bits are retired per cycle; the counter tracks the divide steps
  localparam int CNT_W   = $clog2(COORD_W);

  localparam int        MOVES_W   = 3;
  localparam logic [MOVES_W-1:0] MOVES_MAX = 3'd4;

  localparam logic [3:0] RC_LEFT   = 4'b0001;
  localparam logic [3:0] RC_RIGHT  = 4'b0010;
  localparam logic [3:0] RC_BOTTOM = 4'b0100;
  localparam logic [3:0] RC_TOP    = 4'b1000;

  typedef enum logic [1:0] {
    REG_XMIN = 2'd0,
    REG_YMIN = 2'd1,
    REG_XMAX = 2'd2,
    REG_YMAX = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] clip_start_x;
    logic signed [COORD_W-1:0] clip_start_y;
    logic signed [COORD_W-1:0] clip_end_x;
    logic signed [COORD_W-1:0] clip_end_y;
  } seg_out_t;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_CHECK,
    LS_DIV,
    LS_DONE
  } clip_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_SAT,
    MD_DONE
  } md_state_e;

endpackage

[design/lsc_muldiv.sv]
`timescale 1ns / 1ps

// trunc(a*b/c) with the quotient magnitude saturated at 2^40, zero when c is zero
module lsc_muldiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [lsc_pkg::COORD_W:0] a_i,
  input  logic signed [lsc_pkg::COORD_W:0] b_i,
  input  logic signed [lsc_pkg::COORD_W:0] c_i,
  output logic                             done_o,
  output logic signed [lsc_pkg::QS_W-1:0]  q_o
);
  import lsc_pkg::*;

  localparam logic [QCMP_W-1:0] QLim = QCMP_W'(1) << (QMAG_W - 1);

  md_state_e state_q, state_d;

  logic [COORD_W-1:0]       ua_q, ub_q, uc_q;
  logic                     neg_q;
  logic [COORD_W-1:0]       rem_q, rem_d;
  logic [PROD_W-1:0]        dq_q, dq_div;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [QS_W-1:0]   q_q;
  logic [COORD_W:0]         trial;
  logic [COORD_W-1:0]       rem_w;
  logic [PROD_W-1:0]        dq_w;
  logic [QCMP_W-1:0]        q_ext;
  logic [QMAG_W-1:0]        q_mag;
  logic                     ld_ops, ld_mul, run_div, ld_sat;

  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W:0] v);
    logic [COORD_W:0] n;
    n = v[COORD_W] ? (COORD_W+1)'(0) - v : v;
    return n[COORD_W-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  state_d = (uc_q == '0) ? MD_SAT : MD_DIV;
      MD_DIV:  if (cnt_q == '0) state_d = MD_SAT;
      MD_SAT:  state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_comb begin
    ld_ops  = 1'b0;
    ld_mul  = 1'b0;
    run_div = 1'b0;
    ld_sat  = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      MD_IDLE: ld_ops  = start_i;
      MD_MUL:  ld_mul  = 1'b1;
      MD_DIV:  run_div = 1'b1;
      MD_SAT:  ld_sat  = 1'b1;
      MD_DONE: done_o  = 1'b1;
      default: ;
    endcase
  end

  // restoring division, two quotient bits per cycle
  always_comb begin
    rem_w = rem_q;
    dq_w  = dq_q;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_w, dq_w[PROD_W-1]};
      dq_w  = {dq_w[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, uc_q}) begin
        trial   = trial - {1'b0, uc_q};
        dq_w[0] = 1'b1;
      end
      rem_w = trial[COORD_W-1:0];
    end
    rem_d  = rem_w;
    dq_div = dq_w;
  end

  always_comb begin
    q_ext = QCMP_W'(dq_q);
    q_mag = (q_ext > QLim) ? QLim[QMAG_W-1:0] : q_ext[QMAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_ops) begin
      ua_q  <= mag(a_i);
      ub_q  <= mag(b_i);
      uc_q  <= mag(c_i);
      neg_q <= a_i[COORD_W] ^ b_i[COORD_W] ^ c_i[COORD_W];
    end
    if (ld_mul) begin
      dq_q  <= (uc_q == '0) ? '0 : PROD_W'(ua_q) * PROD_W'(ub_q);
      rem_q <= '0;
      cnt_q <= CNT_W'(COORD_W - 1);
    end
    if (run_div) begin
      dq_q  <= dq_div;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
    if (ld_sat) begin
      q_q <= neg_q ? QS_W'(0) - QS_W'(q_mag) : QS_W'(q_mag);
    end
  end

  assign q_o = q_q;

endmodule

[design/line_segment_clipper.sv]
`timescale 1ns / 1ps

// Cohen-Sutherland clipper for one segment at a time in signed Q8.8, against a window
// set through the write port. Every clip move runs the product and a restoring divide
// on one shared multiply/divide unit that retires two quotient bits a cycle; a segment
// takes up to four moves, or none on a trivial accept or reject.
// The input is ready only between segments; a finished result sits in an output
// register, so the next segment is taken while it waits. Rejected segments come out
// with visible low and all coordinates zero.
module line_segment_clipper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [lsc_pkg::COORD_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lsc_pkg::seg_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lsc_pkg::seg_out_t            out_data_o
);
  import lsc_pkg::*;

  localparam logic signed [SUM_W-1:0] CMax = SUM_W'((64'(1) << (COORD_W - 1)) - 64'(1));
  localparam logic signed [SUM_W-1:0] CMin = ~CMax;

  clip_state_e state_q, state_d;

  logic signed [COORD_W-1:0] xmin_q, ymin_q, xmax_q, ymax_q;
  logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [COORD_W-1:0] edge_q, base_q, new_c, edge_w;
  logic [MOVES_W-1:0]        moves_q;
  logic                      mv_start_q, horiz_q, vis_q;
  seg_out_t                  out_q;
  logic                      out_valid_q;

  logic [3:0]                c1, c2, co;
  logic                      trivial_acc, trivial_rej, horiz_w;
  logic signed [COORD_W:0]   dx, dy, md_a, md_b, md_c;
  logic                      md_start, md_done;
  logic signed [QS_W-1:0]    md_q;
  logic signed [SUM_W-1:0]   sum;
  logic                      accept_in, load_out;

  function automatic logic [3:0] region(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic signed [COORD_W-1:0] x_lo,
    input logic signed [COORD_W-1:0] y_lo,
    input logic signed [COORD_W-1:0] x_hi,
    input logic signed [COORD_W-1:0] y_hi
  );
    logic [3:0] c;
    c = '0;
    if (x < x_lo) c = c | RC_LEFT;
    else if (x > x_hi) c = c | RC_RIGHT;
    if (y < y_lo) c = c | RC_BOTTOM;
    else if (y > y_hi) c = c | RC_TOP;
    return c;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v > CMax) ? CMax : ((v < CMin) ? CMin : v);
    return r[COORD_W-1:0];
  endfunction

  lsc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (md_c),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // region test and move setup for the current endpoints
  always_comb begin
    c1          = region(x1_q, y1_q, xmin_q, ymin_q, xmax_q, ymax_q);
    c2          = region(x2_q, y2_q, xmin_q, ymin_q, xmax_q, ymax_q);
    trivial_acc = (c1 | c2) == '0;
    trivial_rej = ((c1 & c2) != '0) || (moves_q == MOVES_MAX);
    co          = (c1 != '0) ? c1 : c2;
    horiz_w     = (co & (RC_TOP | RC_BOTTOM)) != '0;
    if (horiz_w) begin
      edge_w = ((co & RC_TOP) != '0) ? ymax_q : ymin_q;
    end else begin
      edge_w = ((co & RC_RIGHT) != '0) ? xmax_q : xmin_q;
    end
    dx   = (COORD_W+1)'(x2_q) - (COORD_W+1)'(x1_q);
    dy   = (COORD_W+1)'(y2_q) - (COORD_W+1)'(y1_q);
    md_a = horiz_w ? dx : dy;
    md_c = horiz_w ? dy : dx;
    md_b = (COORD_W+1)'(edge_w) - (horiz_w ? (COORD_W+1)'(y1_q) : (COORD_W+1)'(x1_q));
  end

  always_comb begin
    sum   = SUM_W'(base_q) + SUM_W'(md_q);
    new_c = clamp(sum);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      LS_IDLE:  if (in_valid_i) state_d = LS_CHECK;
      LS_CHECK: state_d = (trivial_acc || trivial_rej) ? LS_DONE : LS_DIV;
      LS_DIV:   if (md_done) state_d = LS_CHECK;
      LS_DONE:  if (!out_valid_q || out_ready_i) state_d = LS_IDLE;
      default:  state_d = LS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    md_start   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      LS_IDLE:  in_ready_o = 1'b1;
      LS_CHECK: md_start   = !(trivial_acc || trivial_rej);
      LS_DONE:  load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept_in = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LS_IDLE;
      out_valid_q <= 1'b0;
      xmin_q      <= '0;
      ymin_q      <= '0;
      xmax_q      <= COORD_W'(32767);
      ymax_q      <= COORD_W'(32767);
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_XMIN: xmin_q <= cfg_data_i;
          REG_YMIN: ymin_q <= cfg_data_i;
          REG_XMAX: xmax_q <= cfg_data_i;
          REG_YMAX: ymax_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      x1_q    <= in_data_i.start_x;
      y1_q    <= in_data_i.start_y;
      x2_q    <= in_data_i.end_x;
      y2_q    <= in_data_i.end_y;
      moves_q <= '0;
    end
    if (state_q == LS_CHECK) begin
      vis_q      <= trivial_acc;
      mv_start_q <= c1 != '0;
      horiz_q    <= horiz_w;
      edge_q     <= edge_w;
      base_q     <= horiz_w ? x1_q : y1_q;
    end
    if (state_q == LS_DIV && md_done) begin
      moves_q <= moves_q + 1'b1;
      if (mv_start_q) begin
        x1_q <= horiz_q ? new_c : edge_q;
        y1_q <= horiz_q ? edge_q : new_c;
      end else begin
        x2_q <= horiz_q ? new_c : edge_q;
        y2_q <= horiz_q ? edge_q : new_c;
      end
    end
    if (load_out) begin
      out_q.visible      <= vis_q;
      out_q.clip_start_x <= vis_q ? x1_q : '0;
      out_q.clip_start_y <= vis_q ? y1_q : '0;
      out_q.clip_end_x   <= vis_q ? x2_q : '0;
      out_q.clip_end_y   <= vis_q ? y2_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_moves_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != LS_IDLE |-> moves_q <= MOVES_MAX)
    else $error("more clip moves than allowed");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> state_q == LS_DIV)
    else $error("divider finished outside a move");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |->
      out_data_o.clip_start_x == '0 && out_data_o.clip_start_y == '0 &&
      out_data_o.clip_end_x == '0 && out_data_o.clip_end_y == '0)
    else $error("rejected word carries coordinates");

  a_visible_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.visible |->
      region(out_data_o.clip_start_x, out_data_o.clip_start_y,
             xmin_q, ymin_q, xmax_q, ymax_q) == '0 &&
      region(out_data_o.clip_end_x, out_data_o.clip_end_y,
             xmin_q, ymin_q, xmax_q, ymax_q) == '0)
    else $error("visible word lies outside the window");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> state_q == LS_CHECK && moves_q == '0)
    else $error("accepted word did not start a region check");

endmodule

[tb/seg_clip_checker.sv]
`timescale 1ns / 1ps

module seg_clip_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [lsc_pkg::COORD_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  lsc_pkg::seg_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  lsc_pkg::seg_out_t           out_data_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          results_o,
  output int                          visible_o
);
  import lsc_pkg::*;

  localparam longint QUOT_SAT  = longint'(1) << 40;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    seg_in_t  seg;
    seg_out_t res;
  } pending_clip_t;

  logic signed [COORD_W-1:0] left_edge, bottom_edge, right_edge, top_edge;
  pending_clip_t clip_q[$];

  function automatic logic [3:0] zone_of(longint x, longint y);
    logic [3:0] z;
    z = 4'b0000;
    if (x < left_edge) z = z | RC_LEFT;
    else if (x > right_edge) z = z | RC_RIGHT;
    if (y < bottom_edge) z = z | RC_BOTTOM;
    else if (y > top_edge) z = z | RC_TOP;
    return z;
  endfunction

  // a*b/c truncated toward zero, magnitude capped at 2^40
  function automatic longint edge_cut(longint a, longint b, longint c);
    longint m;
    logic   neg;
    if (c == 0) return 0;
    neg = (a < 0) ^ (b < 0) ^ (c < 0);
    m = ((a < 0) ? -a : a) * ((b < 0) ? -b : b) / ((c < 0) ? -c : c);
    if (m > QUOT_SAT) m = QUOT_SAT;
    return neg ? -m : m;
  endfunction

  function automatic longint fit_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic seg_out_t clip_segment(seg_in_t seg);
    longint    x1, y1, x2, y2, nx, ny, dx, dy;
    logic [3:0] c1, c2, co;
    int        moves;
    logic      vis, done;
    seg_out_t  r;
    x1 = longint'($signed(seg.start_x));
    y1 = longint'($signed(seg.start_y));
    x2 = longint'($signed(seg.end_x));
    y2 = longint'($signed(seg.end_y));
    c1 = zone_of(x1, y1);
    c2 = zone_of(x2, y2);
    vis = 1'b0;
    done = 1'b0;
    moves = 0;
    while (!done) begin
      if ((c1 | c2) == 4'b0000) begin
        vis = 1'b1;
        done = 1'b1;
      end else if ((c1 & c2) != 4'b0000 || moves == int'(MOVES_MAX)) begin
        done = 1'b1;
      end else begin
        // the start point is moved first whenever it lies outside
        co = (c1 != 4'b0000) ? c1 : c2;
        dx = x2 - x1;
        dy = y2 - y1;
        if ((co & (RC_TOP | RC_BOTTOM)) != 4'b0000) begin
          ny = ((co & RC_TOP) != 4'b0000) ? longint'(top_edge) : longint'(bottom_edge);
          nx = fit_coord(x1 + edge_cut(dx, ny - y1, dy));
        end else begin
          nx = ((co & RC_RIGHT) != 4'b0000) ? longint'(right_edge) : longint'(left_edge);
          ny = fit_coord(y1 + edge_cut(dy, nx - x1, dx));
        end
        if (c1 != 4'b0000) begin
          x1 = nx;
          y1 = ny;
          c1 = zone_of(x1, y1);
        end else begin
          x2 = nx;
          y2 = ny;
          c2 = zone_of(x2, y2);
        end
        moves++;
      end
    end
    r.visible      = vis;
    r.clip_start_x = vis ? x1[COORD_W-1:0] : '0;
    r.clip_start_y = vis ? y1[COORD_W-1:0] : '0;
    r.clip_end_x   = vis ? x2[COORD_W-1:0] : '0;
    r.clip_end_y   = vis ? y2[COORD_W-1:0] : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got, input seg_in_t seg);
    if (want !== got) begin
      errors_o++;
      if (errors_o <= 10)
        $display("%0t: %s wrong for segment (%0d,%0d)-(%0d,%0d): expected %0d, got %0d",
                 $realtime, name, seg.start_x, seg.start_y, seg.end_x, seg.end_y,
                 $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pending_clip_t job;
    if (!rst_ni) begin
      left_edge   <= '0;
      bottom_edge <= '0;
      right_edge  <= 16'sh7fff;
      top_edge    <= 16'sh7fff;
      clip_q.delete();
      errors_o  = 0;
      results_o = 0;
      visible_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (clip_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result word with nothing outstanding: %h", $realtime, out_data_i);
        end else begin
          job = clip_q.pop_front();
          results_o++;
          if (job.res.visible) visible_o++;
          check_field("visible", COORD_W'(job.res.visible), COORD_W'(out_data_i.visible),
                      job.seg);
          check_field("clip_start_x", job.res.clip_start_x, out_data_i.clip_start_x, job.seg);
          check_field("clip_start_y", job.res.clip_start_y, out_data_i.clip_start_y, job.seg);
          check_field("clip_end_x", job.res.clip_end_x, out_data_i.clip_end_x, job.seg);
          check_field("clip_end_y", job.res.clip_end_y, out_data_i.clip_end_y, job.seg);
        end
      end
      if (in_valid_i && in_ready_i) begin
        job.seg = in_data_i;
        job.res = clip_segment(in_data_i);
        clip_q.push_back(job);
      end
      // window changes apply to segments taken after this edge
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_XMIN: left_edge   <= cfg_data_i;
          REG_YMIN: bottom_edge <= cfg_data_i;
          REG_XMAX: right_edge  <= cfg_data_i;
          REG_YMAX: top_edge    <= cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = clip_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lsc_pkg::*;

  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 100;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  cfg_reg_e           cfg_idx  = REG_XMIN;
  logic [COORD_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  seg_in_t            in_data  = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  seg_out_t           out_data;

  int send_idle_pct = 21;
  int recv_idle_pct = 64;
  int segs_sent     = 0;
  int idle_cycles   = 0;
  int errors, pending, results, visible_cnt;

  // window as last written, used to aim random endpoints
  logic signed [COORD_W-1:0] wx_lo = '0, wy_lo = '0;
  logic signed [COORD_W-1:0] wx_hi = 16'sh7fff, wy_hi = 16'sh7fff;

  line_segment_clipper i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  seg_clip_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .visible_o  (visible_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    do @(negedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("stalled for %0d cycles with %0d results outstanding", IDLE_LIMIT, pending);
    $display("Verification failed");
    $finish;
  end

  function automatic seg_in_t mk_seg(int x1, int y1, int x2, int y2);
    seg_in_t s;
    s.start_x = COORD_W'(x1);
    s.start_y = COORD_W'(y1);
    s.end_x   = COORD_W'(x2);
    s.end_y   = COORD_W'(y2);
    return s;
  endfunction

  // mostly around the window, sometimes on its edges or anywhere at all
  function automatic logic [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] lo,
                                                    logic signed [COORD_W-1:0] hi);
    longint a, b, span, v;
    a = (lo < hi) ? longint'(lo) : longint'(hi);
    b = (lo < hi) ? longint'(hi) : longint'(lo);
    span = b - a + 64;
    case ($urandom_range(9))
      0, 1: return COORD_W'($urandom);
      2: v = $urandom_range(1) ? longint'(lo) : longint'(hi);
      3: v = $urandom_range(1) ? a - 1 : b + 1;
      8: v = $urandom_range(1) ? COORD_MIN : COORD_MAX;
      9: v = longint'($urandom_range(32)) - 16;
      default: v = a - span / 2 + longint'($urandom_range(int'(span * 2)));
    endcase
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic seg_in_t random_seg();
    seg_in_t s;
    s.start_x = near_coord(wx_lo, wx_hi);
    s.start_y = near_coord(wy_lo, wy_hi);
    s.end_x   = near_coord(wx_lo, wx_hi);
    s.end_y   = near_coord(wy_lo, wy_hi);
    case ($urandom_range(19))
      0: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      1, 2: s.end_x = s.start_x;
      3, 4: s.end_y = s.start_y;
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_seg(input seg_in_t seg);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    do @(posedge clk); while (!in_ready);
    segs_sent++;
  endtask

  task automatic write_window(input logic signed [COORD_W-1:0] lo_x,
                              input logic signed [COORD_W-1:0] lo_y,
                              input logic signed [COORD_W-1:0] hi_x,
                              input logic signed [COORD_W-1:0] hi_y);
    wx_lo = lo_x;
    wy_lo = lo_y;
    wx_hi = hi_x;
    wy_hi = hi_y;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_XMIN;
    cfg_data <= lo_x;
    @(posedge clk);
    cfg_idx  <= REG_YMIN;
    cfg_data <= lo_y;
    @(posedge clk);
    cfg_idx  <= REG_XMAX;
    cfg_data <= hi_x;
    @(posedge clk);
    cfg_idx  <= REG_YMAX;
    cfg_data <= hi_y;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window is the first quadrant
    send_seg(mk_seg(256, 256, 8192, 12288));
    send_seg(mk_seg(-256, 256, -512, 1280));
    send_seg(mk_seg(-32768, -32768, 32767, 32767));
    send_seg(mk_seg(32767, -32768, -32768, 32767));
    send_seg(mk_seg(256, -1280, 256, 1280));
    send_seg(mk_seg(-1280, 256, 1280, 256));
    send_seg(mk_seg(-1, -1, -1, -1));
    send_seg(mk_seg(0, 0, 0, 0));
    send_seg(mk_seg(4096, 4096, 4096, -32768));
    send_seg(mk_seg(-32768, 16, -32768, 32));
    send_seg(mk_seg(-1, -32768, -32768, -1));
    send_seg(mk_seg(-16, 8, 8, -16));
    send_seg(mk_seg(-1, 32767, 32767, -1));
    send_seg(mk_seg(21845, -21846, -21846, 21845));
    send_seg(mk_seg(32767, 32767, 0, 0));

    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        send_idle_pct = (p < 3) ? 21 : (p < 6) ? 64 : 0;
        recv_idle_pct = (p < 3) ? 64 : (p < 6) ? 21 : 0;
        repeat (4) @(posedge clk);
        case (p)
          1: write_window(-4096, -2048, 6144, 3072);
          2: write_window(-32768, -32768, 32767, 32767);
          3: write_window(256, 256, 256, 256);
          4: write_window(2048, 1024, -1024, -512);   // min above max
          5: write_window(-32768, 32512, -32512, 32767);
          default: write_window(COORD_W'($urandom), COORD_W'($urandom),
                                COORD_W'($urandom), COORD_W'($urandom));
        endcase
      end
      repeat (PHASE_ITEMS) send_seg(random_seg());
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d segments over %0d windows (reset, extreme, single point, inverted, random)",
             segs_sent, N_PHASES);
    $display("%0d results checked: %0d visible, %0d rejected; stalls on both sides and none",
             results, visible_cnt, results - visible_cnt);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
